// ----- rtl/twodo_pkg.sv -----
// Shared types, widths, constants and tables for the three-wheel odometry tracker.
`default_nettype none
package twodo_pkg;

	// Shared shift-add multiplier: magnitude operands and full product.
	localparam int MUL_AW = 56;
	localparam int MUL_BW = 32;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Shared restoring divider.
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 32;

	// Rotation unit: datapath width and number of micro-rotations.
	localparam int COR_W     = 34;
	localparam int COR_STEPS = 30;

	localparam int POS_FRAC_BITS_DEF = 16;

	localparam logic [MUL_BW-1:0] TWO_PI_INV_BAM = 32'd683565276;
	localparam logic [MUL_BW-1:0] HALF_PI_Q30    = 32'd1686629713;
	localparam logic [COR_W-1:0]  CORDIC_GAIN    = 34'd652032874;
	localparam logic [DIV_DW-1:0] SMALL_TURN_DIV = 32'd24;
	localparam logic [31:0]       ONE_Q30        = 32'd1073741824;

	// Configuration register indexes.
	localparam logic [1:0] REG_SIDE_IPC = 2'd0;
	localparam logic [1:0] REG_BACK_IPC = 2'd1;
	localparam logic [1:0] REG_SIDE_OFF = 2'd2;
	localparam logic [1:0] REG_BACK_OFF = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_L,
		ST_MUL_R,
		ST_MUL_S,
		ST_ANGLE,
		ST_DIV_RQ,
		ST_MUL_B,
		ST_COR_I,
		ST_MUL_RAD,
		ST_MUL_RR,
		ST_DIV_24,
		ST_DIV_F,
		ST_MUL_HR,
		ST_MUL_HO,
		ST_MUL_SR,
		ST_MUL_SO,
		ST_COR_P,
		ST_MUL_HC,
		ST_MUL_GS,
		ST_MUL_HS,
		ST_MUL_GC,
		ST_WRITE
	} state_t;

	// Arctangent of 2^-i as a binary angle.
	function automatic logic [29:0] atan_bam(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/twodo_mul.sv -----
// Bit-serial shift-add multiplier of two unsigned magnitudes.
`default_nettype none
module twodo_mul (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [twodo_pkg::MUL_AW-1:0]   a,
	input  wire logic [twodo_pkg::MUL_BW-1:0]   b,
	output logic                                done,
	output logic [twodo_pkg::MUL_PW-1:0]        prod
);
	import twodo_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [MUL_AW-1:0] a_q;
	logic [MUL_AW:0]   hi_q;
	logic [MUL_BW-1:0] lo_q;
	logic [MUL_AW:0]   sum;

	// One multiplier bit per cycle: add the multiplicand, then shift right.
	assign sum = hi_q + ((lo_q[0]) ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(MUL_BW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= {1'b0, sum[MUL_AW:1]};
			lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q[MUL_AW-1:0], lo_q};

endmodule
`default_nettype wire

// ----- rtl/twodo_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module twodo_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [twodo_pkg::DIV_NW-1:0]   num,
	input  wire logic [twodo_pkg::DIV_DW-1:0]   den,
	output logic                                done,
	output logic [twodo_pkg::DIV_NW-1:0]        quo
);
	import twodo_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ----- rtl/twodo_cordic.sv -----
// Iterative rotation unit giving sine and cosine of a binary angle in Q2.30.
`default_nettype none
module twodo_cordic (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [31:0]                 angle,
	output logic                                    done,
	output logic signed [twodo_pkg::COR_W-1:0]      sin_o,
	output logic signed [twodo_pkg::COR_W-1:0]      cos_o
);
	import twodo_pkg::*;

	localparam logic signed [COR_W-1:0] QUARTER = 34'sd1073741824;
	localparam logic signed [COR_W-1:0] HALF    = 34'sd2147483648;

	logic                    run_q;
	logic                    done_q;
	logic [4:0]              cnt_q;
	logic                    neg_q;
	logic signed [COR_W-1:0] x_q, y_q, z_q;
	logic signed [COR_W-1:0] ze, zf;
	logic                    fold;
	logic signed [COR_W-1:0] xs, ys, at;

	// Angles beyond a quarter turn are folded by half a turn and the result negated.
	always_comb begin
		ze   = {{(COR_W-32){angle[31]}}, angle};
		zf   = ze;
		fold = 1'b0;
		if (ze > QUARTER) begin
			zf   = ze - HALF;
			fold = 1'b1;
		end else if (ze < -QUARTER) begin
			zf   = ze + HALF;
			fold = 1'b1;
		end
	end

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = {{(COR_W-30){1'b0}}, atan_bam(cnt_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(COR_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= zf;
			neg_q <= fold;
		end else if (run_q) begin
			if (!z_q[COR_W-1]) begin
				y_q <= y_q + xs;
				x_q <= x_q - ys;
				z_q <= z_q - at;
			end else begin
				y_q <= y_q - xs;
				x_q <= x_q + ys;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign sin_o = neg_q ? -y_q : y_q;
	assign cos_o = neg_q ? -x_q : x_q;

endmodule
`default_nettype wire

// ----- rtl/three_wheel_odometry_tracker.sv -----
// Top level of the three-wheel arc odometry tracker: sequencer and pose state.
//
// Input channel (s_t*): one word per encoder sample, holding the absolute counts
// of the left, right and back tracking wheels. Output channel (m_t*): one word
// per sample, holding the saturating X and Y position in signed fixed point with
// POS_FRAC_BITS fraction bits, and the heading as a binary angle (2^32 per turn).
// Configuration is written through cfg_we/cfg_addr/cfg_data while the block is
// idle; the four registers are the side and back inches per count and the side
// and back wheel offsets.
// A sample is worked through by a sequencer that shares one bit-serial multiplier,
// one bit-serial divider and one iterative rotation unit. Each sample runs twelve
// to fourteen products, one or two quotients and two rotations one after another,
// plus the turn decision and the write. One sample is in work at a time;
// s_tready is high only while the sequencer is idle, so the next sample is
// accepted only once the previous one has been written.
// The result sits in an output register, so when the receiver stalls the next
// sample can still be accepted and worked on; the sequencer only waits at its
// final step until the previous result word has been taken.
// Reset clears the previous counts, the pose and the output valid flag, and loads
// the configuration registers with their default values.
`default_nettype none
module three_wheel_odometry_tracker #(
	parameter int POS_FRAC_BITS = twodo_pkg::POS_FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // left_count, right_count, back_count
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // pos_x, pos_y, heading
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [23:0] cfg_data
);
	import twodo_pkg::*;

	// The working distances carry 20 fraction bits; these align them to the output.
	localparam int SHR = (POS_FRAC_BITS <= 20) ? (20 - POS_FRAC_BITS) : 0;
	localparam int SHL = (POS_FRAC_BITS > 20) ? (POS_FRAC_BITS - 20) : 0;

	state_t state_q, state_d;
	logic   pend_q;

	// Configuration.
	logic [19:0] side_ipc_q, back_ipc_q;
	logic [23:0] side_off_q, back_off_q;

	// Persistent state.
	logic [31:0] last_l_q, last_r_q, last_b_q;
	logic [31:0] acc_x_q, acc_y_q, acc_h_q;

	// Per-sample working registers.
	logic signed [31:0] dl_q, dr_q, ds_q;
	logic signed [52:0] l_q, r_q, s_q;
	logic [30:0]        b_q;
	logic [31:0]        rq_q;
	logic signed [COR_W-1:0] si_q, sp_q, cp_q;
	logic [31:0]        rad_q;
	logic [21:0]        rr_q;
	logic [31:0]        f_q;
	logic signed [57:0] h_q, g_q;
	logic signed [58:0] dx_q, dy_q;

	// Output register.
	logic        m_tvalid_q;
	logic [31:0] out_x_q, out_y_q, out_h_q;

	// Unit interfaces.
	logic              mul_start, div_start, cor_start;
	logic              mul_done, div_done, cor_done, unit_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;
	logic              mul_neg;
	logic [DIV_NW-1:0] div_num, div_q;
	logic [DIV_DW-1:0] div_den;
	logic signed [31:0] cor_z;
	logic signed [COR_W-1:0] cor_s, cor_c;

	// Derived values.
	logic               in_fire, wr_ok;
	logic signed [53:0] diff;
	logic               diff_neg;
	logic [53:0]        md_full;
	logic [52:0]        md;
	logic [30:0]        b_half;
	logic signed [31:0] ib, a_val;
	logic [32:0]        dl_mag, dr_mag, ds_mag;
	logic [52:0]        r_mag, s_mag;
	logic [COR_W-1:0]   si_mag, sp_mag, cp_mag;
	logic [31:0]        two_s_mag;
	logic [57:0]        h_mag, g_mag;
	logic [MUL_PW-1:0]  prod_s;
	logic [57:0]        q30_mag, q30_s;
	logic [MUL_PW:0]    off_ext, off_s;
	logic signed [MUL_PW:0] off_sh;
	logic               is_mul, is_div, is_cor;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign wr_ok    = !m_tvalid_q || m_tready;

	// Turn angle from the left-right distance difference.
	assign diff     = {l_q[52], l_q} - {r_q[52], r_q};
	assign diff_neg = diff[53];
	assign md_full  = diff_neg ? (54'd0 - diff) : diff;
	assign md       = md_full[52:0];
	assign b_half   = {1'b0, b_q[30:1]};
	assign ib       = diff_neg ? (32'd0 - {1'b0, b_half}) : {1'b0, b_half};
	assign a_val    = diff_neg ? (32'd0 - {1'b0, b_q}) : {1'b0, b_q};

	assign dl_mag = dl_q[31] ? (33'd0 - {dl_q[31], dl_q}) : {1'b0, dl_q};
	assign dr_mag = dr_q[31] ? (33'd0 - {dr_q[31], dr_q}) : {1'b0, dr_q};
	assign ds_mag = ds_q[31] ? (33'd0 - {ds_q[31], ds_q}) : {1'b0, ds_q};
	assign r_mag  = r_q[52] ? (53'd0 - r_q) : r_q;
	assign s_mag  = s_q[52] ? (53'd0 - s_q) : s_q;
	assign si_mag = si_q[COR_W-1] ? (34'd0 - si_q) : si_q;
	assign sp_mag = sp_q[COR_W-1] ? (34'd0 - sp_q) : sp_q;
	assign cp_mag = cp_q[COR_W-1] ? (34'd0 - cp_q) : cp_q;
	assign two_s_mag = {si_mag[30:0], 1'b0};
	assign h_mag  = h_q[57] ? (58'd0 - h_q) : h_q;
	assign g_mag  = g_q[57] ? (58'd0 - g_q) : g_q;

	// Signed views of the product: whole, truncated Q30 quotient, and floored by 2^26.
	assign prod_s  = mul_neg ? ('0 - mul_p) : mul_p;
	assign q30_mag = mul_p[MUL_PW-1:30];
	assign q30_s   = mul_neg ? (58'd0 - q30_mag) : q30_mag;
	assign off_ext = {1'b0, mul_p};
	assign off_s   = mul_neg ? ('0 - off_ext) : off_ext;
	assign off_sh  = $signed(off_s) >>> 26;

	assign unit_done = mul_done || div_done || cor_done;

	// Saturating accumulate of a Q.20 distance into a position register.
	function automatic logic [31:0] sat_add(input logic [31:0] acc,
			input logic signed [58:0] q20);
		logic signed [63:0] dw;
		logic signed [64:0] sum;
		logic [31:0]        res;
		dw  = {{5{q20[58]}}, q20};
		dw  = (dw >>> SHR) <<< SHL;
		sum = $signed({{33{acc[31]}}, acc}) + $signed({dw[63], dw});
		if (sum > 65'sd2147483647) begin
			res = 32'h7FFF_FFFF;
		end else if (sum < -65'sd2147483648) begin
			res = 32'h8000_0000;
		end else begin
			res = sum[31:0];
		end
		return res;
	endfunction

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_MUL_L;
			ST_MUL_L:   if (unit_done) state_d = ST_MUL_R;
			ST_MUL_R:   if (unit_done) state_d = ST_MUL_S;
			ST_MUL_S:   if (unit_done) state_d = ST_ANGLE;
			ST_ANGLE: begin
				if (side_off_q == 24'd0 || md == 53'd0
						|| md >= {22'd0, side_off_q, 7'd0}) begin
					state_d = ST_COR_I;
				end else begin
					state_d = ST_DIV_RQ;
				end
			end
			ST_DIV_RQ:  if (unit_done) state_d = ST_MUL_B;
			ST_MUL_B:   if (unit_done) state_d = ST_COR_I;
			ST_COR_I:   if (unit_done) state_d = ST_MUL_RAD;
			ST_MUL_RAD: begin
				if (unit_done) begin
					state_d = (b_q < 31'd33554432) ? ST_MUL_RR : ST_DIV_F;
				end
			end
			ST_MUL_RR:  if (unit_done) state_d = ST_DIV_24;
			ST_DIV_24:  if (unit_done) state_d = ST_MUL_HR;
			ST_DIV_F:   if (unit_done) state_d = ST_MUL_HR;
			ST_MUL_HR:  if (unit_done) state_d = ST_MUL_HO;
			ST_MUL_HO:  if (unit_done) state_d = ST_MUL_SR;
			ST_MUL_SR:  if (unit_done) state_d = ST_MUL_SO;
			ST_MUL_SO:  if (unit_done) state_d = ST_COR_P;
			ST_COR_P:   if (unit_done) state_d = ST_MUL_HC;
			ST_MUL_HC:  if (unit_done) state_d = ST_MUL_GS;
			ST_MUL_GS:  if (unit_done) state_d = ST_MUL_HS;
			ST_MUL_HS:  if (unit_done) state_d = ST_MUL_GC;
			ST_MUL_GC:  if (unit_done) state_d = ST_WRITE;
			ST_WRITE:   if (wr_ok) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Unit operands and starts for each step.
	always_comb begin
		is_mul  = 1'b0;
		is_div  = 1'b0;
		is_cor  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		div_num = '0;
		div_den = '0;
		cor_z   = ib;
		case (state_q)
			ST_MUL_L: begin
				is_mul = 1'b1; mul_a = MUL_AW'(dl_mag); mul_b = MUL_BW'(side_ipc_q);
				mul_neg = dl_q[31];
			end
			ST_MUL_R: begin
				is_mul = 1'b1; mul_a = MUL_AW'(dr_mag); mul_b = MUL_BW'(side_ipc_q);
				mul_neg = dr_q[31];
			end
			ST_MUL_S: begin
				is_mul = 1'b1; mul_a = MUL_AW'(ds_mag); mul_b = MUL_BW'(back_ipc_q);
				mul_neg = ds_q[31];
			end
			ST_DIV_RQ: begin
				is_div = 1'b1; div_num = {8'd0, md[30:0], 25'd0};
				div_den = DIV_DW'(side_off_q);
			end
			ST_MUL_B: begin
				is_mul = 1'b1; mul_a = MUL_AW'(rq_q); mul_b = TWO_PI_INV_BAM;
			end
			ST_COR_I: begin
				is_cor = 1'b1;
			end
			ST_MUL_RAD: begin
				is_mul = 1'b1; mul_a = MUL_AW'(b_q); mul_b = HALF_PI_Q30;
			end
			ST_MUL_RR: begin
				is_mul = 1'b1; mul_a = MUL_AW'(rad_q); mul_b = rad_q;
			end
			ST_DIV_24: begin
				is_div = 1'b1; div_num = DIV_NW'(rr_q); div_den = SMALL_TURN_DIV;
			end
			ST_DIV_F: begin
				is_div = 1'b1; div_num = {2'd0, si_mag[31:0], 30'd0};
				div_den = {1'b0, rad_q[31:1]};
			end
			ST_MUL_HR: begin
				is_mul = 1'b1; mul_a = MUL_AW'(r_mag); mul_b = f_q; mul_neg = r_q[52];
			end
			ST_MUL_HO: begin
				is_mul = 1'b1; mul_a = MUL_AW'(side_off_q); mul_b = two_s_mag;
				mul_neg = si_q[COR_W-1];
			end
			ST_MUL_SR: begin
				is_mul = 1'b1; mul_a = MUL_AW'(s_mag); mul_b = f_q; mul_neg = s_q[52];
			end
			ST_MUL_SO: begin
				is_mul = 1'b1; mul_a = MUL_AW'(back_off_q); mul_b = two_s_mag;
				mul_neg = si_q[COR_W-1];
			end
			ST_COR_P: begin
				is_cor = 1'b1; cor_z = acc_h_q + ib;
			end
			ST_MUL_HC: begin
				is_mul = 1'b1; mul_a = h_mag[MUL_AW-1:0]; mul_b = cp_mag[31:0];
				mul_neg = h_q[57] ^ cp_q[COR_W-1];
			end
			ST_MUL_GS: begin
				is_mul = 1'b1; mul_a = g_mag[MUL_AW-1:0]; mul_b = sp_mag[31:0];
				mul_neg = g_q[57] ^ sp_q[COR_W-1];
			end
			ST_MUL_HS: begin
				is_mul = 1'b1; mul_a = h_mag[MUL_AW-1:0]; mul_b = sp_mag[31:0];
				mul_neg = h_q[57] ^ sp_q[COR_W-1];
			end
			ST_MUL_GC: begin
				is_mul = 1'b1; mul_a = g_mag[MUL_AW-1:0]; mul_b = cp_mag[31:0];
				mul_neg = g_q[57] ^ cp_q[COR_W-1];
			end
			default: begin
				is_mul = 1'b0;
			end
		endcase
		mul_start = is_mul && !pend_q;
		div_start = is_div && !pend_q;
		cor_start = is_cor && !pend_q;
	end

	// Control state, configuration, pose and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_q     <= 1'b0;
			side_ipc_q <= 20'd21412;
			back_ipc_q <= 20'd25164;
			side_off_q <= 24'd364708;
			back_off_q <= 24'd294912;
			last_l_q   <= '0;
			last_r_q   <= '0;
			last_b_q   <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			acc_h_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start || cor_start) begin
				pend_q <= 1'b1;
			end else if (unit_done) begin
				pend_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_SIDE_IPC: side_ipc_q <= cfg_data[19:0];
					REG_BACK_IPC: back_ipc_q <= cfg_data[19:0];
					REG_SIDE_OFF: side_off_q <= cfg_data;
					REG_BACK_OFF: back_off_q <= cfg_data;
					default:      side_off_q <= side_off_q;
				endcase
			end
			if (in_fire) begin
				last_l_q <= s_tdata[31:0];
				last_r_q <= s_tdata[63:32];
				last_b_q <= s_tdata[95:64];
			end
			if (state_q == ST_WRITE && wr_ok) begin
				acc_x_q    <= sat_add(acc_x_q, dx_q);
				acc_y_q    <= sat_add(acc_y_q, dy_q);
				acc_h_q    <= acc_h_q + a_val;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers, loaded as each step completes.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dl_q <= s_tdata[31:0] - last_l_q;
			dr_q <= s_tdata[63:32] - last_r_q;
			ds_q <= s_tdata[95:64] - last_b_q;
		end
		if (state_q == ST_ANGLE) begin
			if (side_off_q == 24'd0 || md == 53'd0) begin
				b_q <= '0;
			end else if (md >= {22'd0, side_off_q, 7'd0}) begin
				b_q <= '1;
			end
		end
		if (state_q == ST_WRITE && wr_ok) begin
			out_x_q <= sat_add(acc_x_q, dx_q);
			out_y_q <= sat_add(acc_y_q, dy_q);
			out_h_q <= acc_h_q + a_val;
		end
		if (unit_done) begin
			case (state_q)
				ST_MUL_L:   l_q <= prod_s[52:0];
				ST_MUL_R:   r_q <= prod_s[52:0];
				ST_MUL_S:   s_q <= prod_s[52:0];
				ST_DIV_RQ:  rq_q <= div_q[31:0];
				ST_MUL_B: begin
					// The turn magnitude stops just short of half a turn.
					b_q <= (|mul_p[MUL_PW-1:61]) ? '1 : mul_p[60:30];
				end
				ST_COR_I:   si_q <= cor_s;
				ST_MUL_RAD: rad_q <= mul_p[61:30];
				ST_MUL_RR:  rr_q <= mul_p[51:30];
				ST_DIV_24:  f_q <= ONE_Q30 - div_q[31:0];
				ST_DIV_F:   f_q <= div_q[31:0];
				ST_MUL_HR:  h_q <= q30_s;
				ST_MUL_HO:  h_q <= h_q + off_sh[57:0];
				ST_MUL_SR:  g_q <= q30_s;
				ST_MUL_SO:  g_q <= g_q + off_sh[57:0];
				ST_COR_P: begin
					sp_q <= cor_s;
					cp_q <= cor_c;
				end
				ST_MUL_HC:  dy_q <= {q30_s[57], q30_s};
				ST_MUL_GS:  dy_q <= dy_q - {q30_s[57], q30_s};
				ST_MUL_HS:  dx_q <= {q30_s[57], q30_s};
				ST_MUL_GC:  dx_q <= dx_q + {q30_s[57], q30_s};
				default:    rq_q <= rq_q;
			endcase
		end
	end

	twodo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	twodo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_q)
	);

	twodo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_z),
		.done   (cor_done),
		.sin_o  (cor_s),
		.cos_o  (cor_c)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_h_q, out_y_q, out_x_q};

endmodule
`default_nettype wire

// ----- bench/odometry_checker.sv -----
// Pose checker for the three-wheel odometry tracker: watches both channels and the register port.
module odometry_checker #(
	parameter int POS_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [95:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [95:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [23:0] cfg_data,
	output int               errors,
	output int               pending,
	output int               poses_seen
);
	import twodo_pkg::*;

	localparam longint unsigned LOW30 = 64'h3FFF_FFFF;

	typedef struct packed {
		logic [31:0] heading;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} pose_t;

	longint arc_table [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	logic [19:0] side_ipc, back_ipc;
	logic [23:0] side_off, back_off;
	logic [31:0] last_l, last_r, last_b, acc_x, acc_y, acc_h;
	pose_t       pose_q[$];

	function automatic longint unsigned mag64(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Product with a Q2.30 factor, truncated toward zero.
	function automatic longint mul_q30(input longint v, input longint f);
		longint unsigned mv, mf, r;
		mv = mag64(v);
		mf = mag64(f);
		r = (mv >> 30) * mf + (((mv & LOW30) * mf) >> 30);
		return ((v < 0) != (f < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic void rotate(input longint z_in, output longint s, output longint c);
		longint x, y, t, z;
		bit     neg;
		x = longint'(CORDIC_GAIN);
		y = 0;
		z = z_in;
		neg = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= (64'sd1 <<< 31);
			neg = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += (64'sd1 <<< 31);
			neg = 1;
		end
		for (int i = 0; i < 30; i++) begin
			t = y >>> i;
			if (z >= 0) begin
				y += x >>> i;
				x -= t;
				z -= arc_table[i];
			end else begin
				y -= x >>> i;
				x += t;
				z += arc_table[i];
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	function automatic logic [31:0] sat_accumulate(input logic [31:0] acc, input longint q20);
		longint d, r;
		if (POS_FRAC_BITS <= 20)
			d = q20 >>> (20 - POS_FRAC_BITS);
		else
			d = q20 <<< (POS_FRAC_BITS - 20);
		r = longint'($signed(acc)) + d;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// Works out the next pose from one encoder sample and advances the state.
	function automatic pose_t advance_pose(input logic [95:0] w);
		logic [31:0]     cl, cr, cb, t32;
		longint          dl, dr, ds, lq, rq20, sq, diff, a, ib, si, ci, sp, cp, f;
		longint          two_s, h, h2, dx, dy;
		longint unsigned md, ma, rad, quo, b;
		pose_t           p;
		cl = w[31:0];
		cr = w[63:32];
		cb = w[95:64];
		t32 = cl - last_l; dl = longint'($signed(t32));
		t32 = cr - last_r; dr = longint'($signed(t32));
		t32 = cb - last_b; ds = longint'($signed(t32));
		lq = dl * longint'(side_ipc);
		rq20 = dr * longint'(side_ipc);
		sq = ds * longint'(back_ipc);
		diff = lq - rq20;
		last_l = cl;
		last_r = cr;
		last_b = cb;

		a = 0;
		md = mag64(diff);
		if (side_off != 0 && md != 0) begin
			if (md >= 64'(side_off) * 128) begin
				b = 64'h7FFF_FFFF;
			end else begin
				quo = (md << 25) / 64'(side_off);
				b = (quo * 64'(TWO_PI_INV_BAM)) >> 30;
				if (b > 64'h7FFF_FFFF)
					b = 64'h7FFF_FFFF;
			end
			a = (diff < 0) ? -longint'(b) : longint'(b);
		end

		ib = (a < 0) ? -longint'(mag64(a) >> 1) : (a >>> 1);
		rotate(ib, si, ci);

		ma = mag64(a);
		rad = (ma * 64'(HALF_PI_Q30)) >> 30;
		if (ma < (64'd1 << 25))
			f = (64'sd1 <<< 30) - longint'(((rad * rad) >> 30) / 24);
		else
			f = longint'((mag64(si) << 30) / (rad >> 1));
		two_s = 2 * si;

		h = mul_q30(rq20, f) + ((two_s * longint'(side_off)) >>> 26);
		h2 = mul_q30(sq, f) + ((two_s * longint'(back_off)) >>> 26);

		t32 = acc_h + ib[31:0];
		rotate(longint'($signed(t32)), sp, cp);

		dy = mul_q30(h, cp) - mul_q30(h2, sp);
		dx = mul_q30(h, sp) + mul_q30(h2, cp);
		acc_x = sat_accumulate(acc_x, dx);
		acc_y = sat_accumulate(acc_y, dy);
		acc_h = acc_h + a[31:0];

		p.pos_x = acc_x;
		p.pos_y = acc_y;
		p.heading = acc_h;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t exp_p, got;
		if (!arst_n) begin
			side_ipc = 20'd21412;
			back_ipc = 20'd25164;
			side_off = 24'd364708;
			back_off = 24'd294912;
			last_l = '0; last_r = '0; last_b = '0;
			acc_x = '0; acc_y = '0; acc_h = '0;
			pose_q.delete();
			errors = 0;
			poses_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SIDE_IPC: side_ipc = cfg_data[19:0];
					REG_BACK_IPC: back_ipc = cfg_data[19:0];
					REG_SIDE_OFF: side_off = cfg_data;
					REG_BACK_OFF: back_off = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pose_q.push_back(advance_pose(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				poses_seen++;
				if (pose_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected pose word %h", $time, m_tdata);
				end else begin
					exp_p = pose_q.pop_front();
					if (got.pos_x !== exp_p.pos_x) begin
						errors++;
						$display("%0t: pos_x expected %h actual %h", $time, exp_p.pos_x, got.pos_x);
					end
					if (got.pos_y !== exp_p.pos_y) begin
						errors++;
						$display("%0t: pos_y expected %h actual %h", $time, exp_p.pos_y, got.pos_y);
					end
					if (got.heading !== exp_p.heading) begin
						errors++;
						$display("%0t: heading expected %h actual %h", $time,
							exp_p.heading, got.heading);
					end
				end
			end
		end
		pending = pose_q.size();
	end
endmodule

// ----- bench/tb_top.sv -----
// Stimulus, clocking and verdict for the three-wheel odometry tracker bench.
module tb_top;
	import twodo_pkg::*;

	// The idle watchdog must comfortably cover one sample plus the long hold-off.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int RANDOM_ITEMS   = 575;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [95:0] s_tdata;          // left_count, right_count, back_count
	logic        m_tvalid, m_tready;
	logic [95:0] m_tdata;          // pos_x, pos_y, heading
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [23:0] cfg_data;
	int          errors, pending, poses_seen;
	int          idle_cycles;
	int          samples_sent;
	int          configs_run;
	bit          sender_burst;
	logic [31:0] cur_l, cur_r, cur_b;

	three_wheel_odometry_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	odometry_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .poses_seen(poses_seen)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a run of cycles with no word moving on either channel means
	// the block has hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: a random pause before taking each pose word, with bursts of
	// no pausing, and one long hold-off so that the output register fills up
	// and the block has to stall its input side.
	initial begin
		int  gap, taken;
		bit  burst, rdy;
		m_tready = 1'b0;
		taken = 0;
		burst = 0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			gap = burst ? 0 : $urandom_range(0, 10);
			if (taken == 120)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			forever begin
				@(negedge clk);
				rdy = m_tvalid;
				@(posedge clk);
				if (rdy)
					break;
			end
			taken++;
		end
	end

	// Offers one sample word. Valid is only lowered when a pause follows,
	// so back-to-back words keep it high across the edge.
	task automatic send_sample(input logic [31:0] l, input logic [31:0] r, input logic [31:0] b);
		int gap;
		bit rdy;
		if (samples_sent % 50 == 0)
			sender_burst = ($urandom_range(0, 2) == 0);
		gap = sender_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, r, l};
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy)
				break;
		end
		cur_l = l;
		cur_r = r;
		cur_b = b;
		samples_sent++;
	endtask

	// Lets every outstanding pose drain so that registers change only while
	// the sequencer is idle, then a little extra margin. The first wait lets
	// the checker record a word accepted at the edge just passed.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input logic [19:0] side_ipc, input logic [19:0] back_ipc,
		input logic [23:0] side_off, input logic [23:0] back_off);
		drain();
		write_reg(REG_SIDE_IPC, {4'b0, side_ipc});
		write_reg(REG_BACK_IPC, {4'b0, back_ipc});
		write_reg(REG_SIDE_OFF, side_off);
		write_reg(REG_BACK_OFF, back_off);
		configs_run++;
	endtask

	// Mostly realistic motion: small signed steps from the last counts, so
	// that the pose builds up over many samples. Now and then a wild jump with
	// fully random counts, which exercises the big-turn and saturation paths.
	task automatic random_sample();
		int          kind;
		logic [31:0] dl, dr, db;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			send_sample($urandom, $urandom, $urandom);
		end else begin
			dl = $urandom_range(0, 4000) - 2000;
			dr = (kind < 4) ? dl : $urandom_range(0, 4000) - 2000;
			db = $urandom_range(0, 2000) - 1000;
			if (kind == 9) begin
				dl = $urandom_range(0, 200000) - 100000;
				dr = -dl;
			end
			send_sample(cur_l + dl, cur_r + dr, cur_b + db);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		idle_cycles = 0;
		samples_sent = 0;
		configs_run = 0;
		sender_burst = 0;
		cur_l = '0; cur_r = '0; cur_b = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset geometry: standing still, a straight
		// run, pure turns both ways, a tiny turn, counter wrap at both ends,
		// and the full-scale counts that saturate the turn.
		send_sample(32'd0, 32'd0, 32'd0);
		send_sample(32'd1000, 32'd1000, 32'd0);
		send_sample(32'd1001, 32'd1000, 32'd1);
		send_sample(32'd1500, 32'd500, 32'd300);
		send_sample(32'd500, 32'd1500, -32'sd300);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h0000_0010, 32'h0000_0010, 32'h0000_0005);
		send_sample(32'h8000_0000, 32'h8000_0000, 32'h0);

		// Largest scales and offsets: positions run into saturation.
		set_geometry(20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_sample(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(32'hC000_0000, 32'hC000_0000, 32'hC000_0000);
		send_sample(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
		send_sample(32'h5000_0000, 32'h1000_0000, 32'h0);

		// Zero side offset forces straight motion whatever the wheels do.
		set_geometry(20'd21412, 20'd25164, 24'd0, 24'd294912);
		send_sample(32'd5000, 32'd100, 32'd77);
		send_sample(32'd100, 32'd5000, 32'd0);

		// Zero scales and the smallest offsets.
		set_geometry(20'd0, 20'd0, 24'd1, 24'd0);
		send_sample(32'd12345, 32'd54321, 32'd999);
		set_geometry(20'd1, 20'd1, 24'd1, 24'd1);
		send_sample(32'd12346, 32'd54321, 32'd1000);
		send_sample(32'd12346, 32'd54300, 32'd1000);

		// Random part in phases, each under its own geometry; the first and
		// last use the defaults and a typical robot, the middle ones random
		// and extreme values.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_geometry(20'd21412, 20'd25164, 24'd364708, 24'd294912);
				1: set_geometry(20'($urandom), 20'($urandom), 24'($urandom), 24'($urandom));
				2: set_geometry(20'hFFFFF, 20'd1, 24'($urandom_range(1, 1000)), 24'hFFFFFF);
				3: set_geometry(20'($urandom_range(1, 100000)), 20'($urandom_range(1, 100000)),
					24'($urandom_range(65536, 2000000)), 24'($urandom_range(0, 2000000)));
				default: set_geometry(20'd30000, 20'd30000, 24'd500000, 24'd200000);
			endcase
			for (int i = 0; i < RANDOM_ITEMS / 5; i++)
				random_sample();
		end

		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d encoder samples over %0d register settings; %0d poses checked.",
			samples_sent, configs_run + 1, poses_seen);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- three_wheel_odometry_tracker.f -----
rtl/twodo_pkg.sv
rtl/twodo_mul.sv
rtl/twodo_div.sv
rtl/twodo_cordic.sv
rtl/three_wheel_odometry_tracker.sv
bench/odometry_checker.sv
bench/tb_top.sv
